@@ src/fiwd_pkg.sv @@
`default_nettype none
package fiwd_pkg;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int N_COORDS       = 9;
	localparam int OUT_W          = 32;
endpackage
`default_nettype wire

@@ src/face_interp_weight_delta_top.sv @@
// Stages in order: differences, squares, sum, square root, divider setup, division, output.
// Throughput: one face per cycle; a stall at the output freezes every stage at once.
// The square root resolves one root bit per stage, each divider one quotient bit per stage.
// Reset (arst_n, asynchronous, active low) clears only the stage valid bits; the
// datapath registers are not reset.
`default_nettype none
module face_interp_weight_delta_top
	import fiwd_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// face_x, face_y, face_z, owner_x, owner_y, owner_z, nbr_x, nbr_y, nbr_z
	input  wire logic [N_COORDS*FIELD_W-1:0]   s_tdata,
	// is_boundary
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// interp_factor, inv_distance
	output logic [2*OUT_W-1:0]                 m_tdata,
	// degenerate
	output logic                               m_tuser
);
	localparam int CW   = COORD_BITS;
	localparam int SW   = 2 * CW + 2;   // sum of three squares
	localparam int RW   = CW + 1;       // square root
	localparam int NWA  = (RW + FRAC_BITS > 2 * FRAC_BITS + 1) ? RW + FRAC_BITS
	                                                            : 2 * FRAC_BITS + 1;
	localparam int NW   = (NWA > OUT_W + 1) ? NWA : OUT_W + 1;

	// The whole pipeline moves together; it holds only when the output is full and not taken.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	function automatic logic signed [CW-1:0] ext(input logic [FIELD_W-1:0] v);
		logic [63:0] w;
		w = {{(64-FIELD_W){v[FIELD_W-1]}}, v};
		return w[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] d;
		logic [CW:0] nd;
		d  = {b[CW-1], b} - {a[CW-1], a};
		nd = -d;
		return d[CW] ? nd[CW-1:0] : d[CW-1:0];
	endfunction

	// Stage 1: coordinate differences. Length one is face to neighbour; length two is
	// owner to neighbour, or face to owner on a boundary face.
	logic [CW-1:0] m1_c [3];
	logic [CW-1:0] m2_c [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			m1_c[a] = absd(ext(s_tdata[FIELD_W*a +: FIELD_W]),
			               ext(s_tdata[FIELD_W*(6+a) +: FIELD_W]));
			m2_c[a] = s_tuser ? absd(ext(s_tdata[FIELD_W*a +: FIELD_W]),
			                         ext(s_tdata[FIELD_W*(3+a) +: FIELD_W]))
			                  : absd(ext(s_tdata[FIELD_W*(3+a) +: FIELD_W]),
			                         ext(s_tdata[FIELD_W*(6+a) +: FIELD_W]));
		end
	end

	logic [CW-1:0]   m1_s1 [3];
	logic [CW-1:0]   m2_s1 [3];
	logic            bnd_s1, vld_s1;
	logic [2*CW-1:0] q1_s2 [3];
	logic [2*CW-1:0] q2_s2 [3];
	logic            bnd_s2, vld_s2;
	logic [SW-1:0]   sum1_s3, sum2_s3;
	logic            bnd_s3, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 2 squares each difference; stage 3 adds the three squares.
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1  <= m1_c;
			m2_s1  <= m2_c;
			bnd_s1 <= s_tuser;
			for (int a = 0; a < 3; a++) begin
				q1_s2[a] <= (2*CW)'(m1_s1[a]) * (2*CW)'(m1_s1[a]);
				q2_s2[a] <= (2*CW)'(m2_s1[a]) * (2*CW)'(m2_s1[a]);
			end
			bnd_s2  <= bnd_s1;
			sum1_s3 <= SW'(q1_s2[0]) + SW'(q1_s2[1]) + SW'(q1_s2[2]);
			sum2_s3 <= SW'(q2_s2[0]) + SW'(q2_s2[1]) + SW'(q2_s2[2]);
			bnd_s3  <= bnd_s2;
		end
	end

	// Square root stages: each decides one root bit, most significant first, keeping the
	// remainder of the sum less the square of the partial root.
	logic [SW-1:0] rem1_sk  [RW+1];
	logic [SW-1:0] rem2_sk  [RW+1];
	logic [RW-1:0] root1_sk [RW+1];
	logic [RW-1:0] root2_sk [RW+1];
	logic          bnd_sk   [RW+1];
	logic          vld_sk   [RW+1];

	assign rem1_sk[0]  = sum1_s3;
	assign rem2_sk[0]  = sum2_s3;
	assign root1_sk[0] = '0;
	assign root2_sk[0] = '0;
	assign bnd_sk[0]   = bnd_s3;
	assign vld_sk[0]   = vld_s3;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int BI = RW - 1 - k;
		logic [SW:0] t1, t2;
		logic        ok1, ok2;
		always_comb begin
			t1  = ({{(SW+1-RW){1'b0}}, root1_sk[k]} << (BI + 1)) | ((SW+1)'(1) << (2 * BI));
			t2  = ({{(SW+1-RW){1'b0}}, root2_sk[k]} << (BI + 1)) | ((SW+1)'(1) << (2 * BI));
			ok1 = t1 <= {1'b0, rem1_sk[k]};
			ok2 = t2 <= {1'b0, rem2_sk[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (en) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem1_sk[k+1]  <= ok1 ? rem1_sk[k] - t1[SW-1:0] : rem1_sk[k];
				rem2_sk[k+1]  <= ok2 ? rem2_sk[k] - t2[SW-1:0] : rem2_sk[k];
				root1_sk[k+1] <= ok1 ? root1_sk[k] | (RW'(1) << BI) : root1_sk[k];
				root2_sk[k+1] <= ok2 ? root2_sk[k] | (RW'(1) << BI) : root2_sk[k];
				bnd_sk[k+1]   <= bnd_sk[k];
			end
		end
	end

	// Divider setup: a quotient overflows 32 bits when the numerator's upper part already
	// reaches the divisor; a zero divisor falls under the same test.
	logic [NW-1:0] numf_c, numi_c, hif_c, hii_c, den_w;
	always_comb begin
		numf_c = NW'(root1_sk[RW]) << FRAC_BITS;
		numi_c = NW'(1) << (2 * FRAC_BITS);
		hif_c  = numf_c >> OUT_W;
		hii_c  = numi_c >> OUT_W;
		den_w  = NW'(root2_sk[RW]);
	end

	logic [RW-1:0]    remf_dj [OUT_W+1];
	logic [RW-1:0]    remi_dj [OUT_W+1];
	logic [OUT_W-1:0] numf_dj [OUT_W+1];
	logic [OUT_W-1:0] numi_dj [OUT_W+1];
	logic [OUT_W-1:0] qf_dj   [OUT_W+1];
	logic [OUT_W-1:0] qi_dj   [OUT_W+1];
	logic [RW-1:0]    den_dj  [OUT_W+1];
	logic             ovff_dj [OUT_W+1];
	logic             ovfi_dj [OUT_W+1];
	logic             bnd_dj  [OUT_W+1];
	logic             vld_dj  [OUT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dj[0] <= 1'b0;
		end else if (en) begin
			vld_dj[0] <= vld_sk[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			remf_dj[0] <= hif_c[RW-1:0];
			remi_dj[0] <= hii_c[RW-1:0];
			numf_dj[0] <= numf_c[OUT_W-1:0];
			numi_dj[0] <= numi_c[OUT_W-1:0];
			qf_dj[0]   <= '0;
			qi_dj[0]   <= '0;
			den_dj[0]  <= root2_sk[RW];
			ovff_dj[0] <= hif_c >= den_w;
			ovfi_dj[0] <= hii_c >= den_w;
			bnd_dj[0]  <= bnd_sk[RW];
		end
	end

	// Restoring division, one quotient bit per stage for both quotients at once.
	for (genvar j = 0; j < OUT_W; j++) begin : g_div
		logic [RW:0] wf, wi, dz;
		logic        gef, gei;
		always_comb begin
			wf  = {remf_dj[j], numf_dj[j][OUT_W-1]};
			wi  = {remi_dj[j], numi_dj[j][OUT_W-1]};
			dz  = {1'b0, den_dj[j]};
			gef = wf >= dz;
			gei = wi >= dz;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dj[j+1] <= 1'b0;
			end else if (en) begin
				vld_dj[j+1] <= vld_dj[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				remf_dj[j+1] <= gef ? RW'(wf - dz) : wf[RW-1:0];
				remi_dj[j+1] <= gei ? RW'(wi - dz) : wi[RW-1:0];
				numf_dj[j+1] <= numf_dj[j] << 1;
				numi_dj[j+1] <= numi_dj[j] << 1;
				qf_dj[j+1]   <= {qf_dj[j][OUT_W-2:0], gef};
				qi_dj[j+1]   <= {qi_dj[j][OUT_W-2:0], gei};
				den_dj[j+1]  <= den_dj[j];
				ovff_dj[j+1] <= ovff_dj[j];
				ovfi_dj[j+1] <= ovfi_dj[j];
				bnd_dj[j+1]  <= bnd_dj[j];
			end
		end
	end

	// Output register: a boundary face reports a factor of exactly one and ignores the
	// factor divider; a saturated quotient reads as all ones and marks the face degenerate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_dj[OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[OUT_W-1:0]       <= bnd_dj[OUT_W] ? (OUT_W'(1) << FRAC_BITS)
			                          : (ovff_dj[OUT_W] ? '1 : qf_dj[OUT_W]);
			m_tdata[2*OUT_W-1:OUT_W] <= ovfi_dj[OUT_W] ? '1 : qi_dj[OUT_W];
			m_tuser                  <= ovfi_dj[OUT_W] || (!bnd_dj[OUT_W] && ovff_dj[OUT_W]);
		end
	end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
	import fiwd_pkg::*;

	localparam int N_RANDOM   = 830;
	localparam int QUIET_MAX  = 20000;
	localparam int DRAIN_WAIT = 200;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic               boundary;
		logic signed [31:0] c [N_COORDS];
	} face_t;

	typedef struct {
		logic [31:0] factor;
		logic [31:0] inv;
		logic        deg;
	} weight_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [N_COORDS*FIELD_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*OUT_W-1:0] m_tdata;
	logic m_tuser;

	face_t   face_q [$];
	weight_t weight_q [$];
	face_t   offered;
	int      total_faces;
	int      sent = 0;
	int      errors = 0;
	int      quiet = 0;
	bit      pause_done = 0;
	bit      hold_done = 0;
	int      hold_left = 0;

	face_interp_weight_delta_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Euclidean length between points starting at coordinate indexes pa and pb,
	// root rounded down.
	function automatic logic [63:0] point_dist(face_t f, int pa, int pb);
		logic [127:0] acc;
		logic [127:0] cand;
		logic [63:0]  root;
		logic signed [63:0] d;
		logic [63:0] m;
		acc = '0;
		root = '0;
		for (int i = 0; i < 3; i++) begin
			d = 64'(f.c[pb+i]) - 64'(f.c[pa+i]);
			m = d < 0 ? -d : d;
			acc += 128'(m) * 128'(m);
		end
		for (int i = 63; i >= 0; i--) begin
			cand = 128'(root | (64'd1 << i));
			if (cand * cand <= acc)
				root = cand[63:0];
		end
		return root;
	endfunction

	// Truncating quotient, saturated to 32 bits.
	function automatic logic [31:0] sat_quot(logic [127:0] num, logic [63:0] den,
			inout logic deg);
		logic [127:0] q;
		q = num / 128'(den);
		if (q[127:32] != '0) begin
			deg = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic weight_t face_weight(face_t f);
		weight_t w;
		logic [63:0] dfo, dfn, don;
		logic [127:0] one;
		one = 128'd1 << (2 * FRAC_BITS_DEF);
		w.deg = 1'b0;
		if (f.boundary) begin
			dfo = point_dist(f, 0, 3);
			w.factor = 32'd1 << FRAC_BITS_DEF;
			if (dfo == 0) begin
				w.deg = 1'b1;
				w.inv = 32'hFFFF_FFFF;
			end else begin
				w.inv = sat_quot(one, dfo, w.deg);
			end
		end else begin
			dfn = point_dist(f, 0, 6);
			don = point_dist(f, 3, 6);
			if (don == 0) begin
				w.deg = 1'b1;
				w.factor = 32'hFFFF_FFFF;
				w.inv = 32'hFFFF_FFFF;
			end else begin
				w.factor = sat_quot(128'(dfn) << FRAC_BITS_DEF, don, w.deg);
				w.inv = sat_quot(one, don, w.deg);
			end
		end
		return w;
	endfunction

	function automatic logic signed [31:0] rand_offset();
		int sh;
		sh = $urandom_range(31);
		return $signed($urandom) >>> sh;
	endfunction

	// Random face: mostly nearby points so that results stay in range, some wild.
	function automatic face_t rand_face();
		face_t f;
		logic signed [31:0] base;
		f.boundary = $urandom_range(3) == 0;
		for (int k = 0; k < 3; k++) begin
			base = $urandom;
			if ($urandom_range(9) < 2) begin
				f.c[k] = $urandom; f.c[3+k] = $urandom; f.c[6+k] = $urandom;
			end else begin
				f.c[k] = base + rand_offset();
				f.c[3+k] = base + rand_offset();
				f.c[6+k] = base + rand_offset();
			end
		end
		if ($urandom_range(19) == 0)
			for (int k = 0; k < 3; k++) f.c[6+k] = f.c[3+k];
		return f;
	endfunction

	function automatic face_t fixed_face(logic b, logic signed [31:0] fv,
			logic signed [31:0] ov, logic signed [31:0] nv);
		face_t f;
		f.boundary = b;
		for (int k = 0; k < 3; k++) begin
			f.c[k] = fv; f.c[3+k] = ov; f.c[6+k] = nv;
		end
		return f;
	endfunction

	// Sender: each transfer is predicted as it happens, then the next face is offered.
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				weight_q.push_back(face_weight(offered));
				sent++;
			end
			idle_pct = sent < total_faces / 3 ? 24 : (sent < 2 * total_faces / 3 ? 57 : 0);
			if (!pause_done && sent >= 2 * total_faces / 3 + 50) begin
				// Let the whole pipeline run dry once before going on.
				if (weight_q.size() == 0)
					pause_done = 1;
			end
			if (!s_tvalid || s_tready) begin
				if (face_q.size() != 0 && $urandom_range(99) >= idle_pct
						&& (pause_done || sent < 2 * total_faces / 3 + 50)) begin
					offered = face_q.pop_front();
					s_tuser <= offered.boundary;
					for (int k = 0; k < N_COORDS; k++)
						s_tdata[k*FIELD_W +: FIELD_W] <= offered.c[k];
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		weight_t w;
		int idle_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("watchdog: no transfer for %0d cycles", quiet);
				$display("status: fail");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (weight_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h deg %b", m_tdata, m_tuser);
				end else begin
					w = weight_q.pop_front();
					if (m_tdata[31:0] !== w.factor || m_tdata[63:32] !== w.inv
							|| m_tuser !== w.deg) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp factor %h inv %h deg %b, got %h %h %b",
								w.factor, w.inv, w.deg,
								m_tdata[31:0], m_tdata[63:32], m_tuser);
					end
				end
			end
			// One long hold-off in the middle of the run so the pipeline backs up.
			if (!hold_done && sent >= total_faces / 4) begin
				hold_done = 1;
				hold_left = HOLD_LEN;
			end
			idle_pct = sent < total_faces / 3 ? 57 : (sent < 2 * total_faces / 3 ? 24 : 0);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= idle_pct;
			end
		end
	end

	initial begin
		face_t f;
		// Degenerate and boundary cases first.
		face_q.push_back(fixed_face(1'b1, 0, 0, 0));
		face_q.push_back(fixed_face(1'b0, 0, 0, 0));
		face_q.push_back(fixed_face(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
		face_q.push_back(fixed_face(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		face_q.push_back(fixed_face(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
		face_q.push_back(fixed_face(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678));
		face_q.push_back(fixed_face(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF));
		face_q.push_back(fixed_face(1'b1, 0, 32'sh0001_0000, 32'sh7FFF_FFFF));
		face_q.push_back(fixed_face(1'b1, 0, 1, 0));
		face_q.push_back(fixed_face(1'b0, 0, 0, 1));
		face_q.push_back(fixed_face(1'b0, 32'sh0001_0000, 0, 32'sh0002_0000));
		face_q.push_back(fixed_face(1'b0, 32'sh7000_0000, 0, 32'sh0000_0100));
		face_q.push_back(fixed_face(1'b0, -1, -1, 32'sh0010_0000));
		face_q.push_back(fixed_face(1'b0, 32'sh0000_8000, 0, 32'sh0001_0000));
		face_q.push_back(fixed_face(1'b1, -1, 0, -1));
		f = fixed_face(1'b0, 0, 0, 0);
		f.c[6] = 32'sh0003_0000; f.c[7] = 32'sh0004_0000; f.c[8] = 0;
		face_q.push_back(f);
		f = fixed_face(1'b1, 32'sh5555_5555, 32'shAAAA_AAAA, 0);
		face_q.push_back(f);
		f = fixed_face(1'b0, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
		f.c[5] = 32'sh5555_5556;
		face_q.push_back(f);
		for (int i = 0; i < N_RANDOM; i++)
			face_q.push_back(rand_face());
		total_faces = face_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (face_q.size() != 0 || s_tvalid || weight_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
